// ----- design/dlfb_pkg.sv -----
// Package: shared types, constants and codes for the dense layer engine.
package dlfb_pkg;

   localparam int MaxIn    = 16;
   localparam int MaxOut   = 16;
   localparam int MaxBatch = 8;

   typedef enum logic [2:0] {
      CMD_LOAD_W  = 3'd0,
      CMD_LOAD_B  = 3'd1,
      CMD_FWD     = 3'd2,
      CMD_BWD     = 3'd3,
      CMD_RD_WG   = 3'd4,
      CMD_RD_BG   = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_FWD = 2'd0,
      KIND_IG  = 2'd1,
      KIND_WG  = 2'd2,
      KIND_BG  = 2'd3
   } kind_type;

   localparam logic [1:0] REG_IN_COUNT    = 2'd0;
   localparam logic [1:0] REG_OUT_COUNT   = 2'd1;
   localparam logic [1:0] REG_BATCH_COUNT = 2'd2;

   typedef struct packed {
      logic [2:0]         command;
      logic [2:0]         sample;
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [15:0] operand;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [3:0]         index;
      logic signed [31:0] result;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FWD_RD,   // issue weight/activation reads for one product
      ST_FWD_MAC,  // accumulate
      ST_FWD_OUT,
      ST_BWD_RD,   // backward gradient update: read act and old grad
      ST_BWD_UPD,  // write updated weight grad (and bias grad at column zero)
      ST_IG_RD,
      ST_IG_MAC,
      ST_IG_OUT,
      ST_GR_RD,
      ST_GR_OUT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clr_acc;     // load accumulator with start value
      logic use_bias;    // start value is bias (else zero)
      logic mac;         // add product into accumulator
      logic wg_write;    // write updated weight gradient
      logic bg_write;    // write updated bias gradient
      logic emit;        // present a result
      logic [1:0] kind;
      logic last;
   } ctl_type;

   // 32-bit saturation of a wide signed sum
   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sd2147483647) r = 32'sh7fffffff;
      else if (v < -48'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ----- design/dense_layer_forward_backward.sv -----
// Top level: dense layer engine with APB-style register port.
// A command beat is taken when start is high and busy low. Loads and stores of
// non-final elements leave the block idle. A sample's last forward element runs,
// per output row on the single multiply-accumulate unit, a read and accumulate
// per input, then an emit; a last backward element runs a read and an update per
// weight gradient, then per input a read and accumulate per output row and an emit;
// a gradient read is a read then an emit. Results appear for one cycle on rsp_valid
// and cannot be stalled. Registers: in_count at 0x0, out_count 0x4, batch_count 0x8.
module dense_layer_forward_backward #(
   parameter int MAX_IN    = dlfb_pkg::MaxIn,
   parameter int MAX_OUT   = dlfb_pkg::MaxOut,
   parameter int MAX_BATCH = dlfb_pkg::MaxBatch
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dlfb_pkg::req_type req_data,
   output logic              rsp_valid,
   output dlfb_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   logic [4:0] in_count_ff, out_count_ff;
   logic [3:0] batch_count_ff;
   logic       wr;
   logic [1:0] ridx;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign ridx = csr_paddr[3:2];

   function automatic logic [4:0] clampc(input logic [4:0] v, input int hi);
      logic [4:0] r;
      if (v == '0) r = 5'd1;
      else if (32'(v) > hi) r = 5'(hi);
      else r = v;
      return r;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff    <= 5'(16 > MAX_IN ? MAX_IN : 16);
         out_count_ff   <= 5'(16 > MAX_OUT ? MAX_OUT : 16);
         batch_count_ff <= 4'(8 > MAX_BATCH ? MAX_BATCH : 8);
      end else if (wr) begin
         case (ridx)
            dlfb_pkg::REG_IN_COUNT:  in_count_ff <= clampc(csr_pwdata[4:0], MAX_IN);
            dlfb_pkg::REG_OUT_COUNT: out_count_ff <= clampc(csr_pwdata[4:0], MAX_OUT);
            dlfb_pkg::REG_BATCH_COUNT:
               batch_count_ff <= 4'(clampc({1'b0, csr_pwdata[3:0]}, MAX_BATCH));
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         dlfb_pkg::REG_IN_COUNT:    csr_prdata = {27'd0, in_count_ff};
         dlfb_pkg::REG_OUT_COUNT:   csr_prdata = {27'd0, out_count_ff};
         dlfb_pkg::REG_BATCH_COUNT: csr_prdata = {28'd0, batch_count_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   logic accept;
   logic [3:0] row_idx, col_idx;
   logic [2:0] smp_idx;
   logic smp_zero;
   dlfb_pkg::cmd_type cmd;
   dlfb_pkg::ctl_type ctl;

   assign accept = start && !busy;

   dlfb_ctrl #(.MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT), .MAX_BATCH(MAX_BATCH)) u_ctrl (
      .clock, .reset, .start, .req(req_data), .in_count(in_count_ff),
      .out_count(out_count_ff), .batch_count(batch_count_ff), .busy,
      .row_idx, .col_idx, .smp_idx, .smp_zero, .cmd, .ctl);

   dlfb_dp #(.MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT), .MAX_BATCH(MAX_BATCH)) u_dp (
      .clock, .reset, .accept, .req(req_data), .in_count(in_count_ff),
      .out_count(out_count_ff), .batch_count(batch_count_ff), .row_idx, .col_idx,
      .smp_idx, .smp_zero, .cmd, .ctl, .rsp_valid, .rsp(rsp_data));

`ifndef ASSERT_OFF
   // a result only ever follows a cycle of work
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without work");
   // the last result of a run returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> !busy) else $error("busy after last result");
   // gradient read returns a single result with last set
   a_rd_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind == dlfb_pkg::KIND_WG || rsp_data.kind == dlfb_pkg::KIND_BG))
      |-> rsp_data.last) else $error("gradient read without last");
`endif
endmodule

// ----- design/dlfb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dlfb_ram #(
   parameter int Width = 16,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- design/dlfb_ctrl.sv -----
// Controller: sequences loads, forward, backward and gradient reads.
module dlfb_ctrl #(
   parameter int MAX_IN    = dlfb_pkg::MaxIn,
   parameter int MAX_OUT   = dlfb_pkg::MaxOut,
   parameter int MAX_BATCH = dlfb_pkg::MaxBatch
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  dlfb_pkg::req_type    req,
   input  logic [4:0]           in_count,
   input  logic [4:0]           out_count,
   input  logic [3:0]           batch_count,
   output logic                 busy,
   output logic [3:0]           row_idx,
   output logic [3:0]           col_idx,
   output logic [2:0]           smp_idx,
   output logic                 smp_zero,
   output dlfb_pkg::cmd_type    cmd,
   output dlfb_pkg::ctl_type    ctl
);
   dlfb_pkg::state_type state_ff, state_in;
   logic [3:0] r_ff, r_in, c_ff, c_in;
   logic [2:0] s_ff, s_in;
   dlfb_pkg::cmd_type cmd_ff, cmd_in;
   logic [3:0] ilast, olast;

   assign ilast = 4'(in_count - 5'd1);
   assign olast = 4'(out_count - 5'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dlfb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      r_ff   <= r_in;
      c_ff   <= c_in;
      s_ff   <= s_in;
      cmd_ff <= cmd_in;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      r_in = r_ff;
      c_in = c_ff;
      s_in = s_ff;
      cmd_in = cmd_ff;
      ctl = '0;
      busy = (state_ff != dlfb_pkg::ST_IDLE);
      case (state_ff)
         dlfb_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in = dlfb_pkg::cmd_type'(req.command);
               s_in = req.sample;
               r_in = req.row;
               c_in = req.col;
               case (req.command)
                  dlfb_pkg::CMD_FWD: begin
                     if ({1'b0, req.sample} < batch_count && {1'b0, req.col} < in_count
                         && req.col == ilast) begin
                        state_in = dlfb_pkg::ST_FWD_RD;
                        r_in = '0;
                        c_in = '0;
                     end
                  end
                  dlfb_pkg::CMD_BWD: begin
                     if ({1'b0, req.sample} < batch_count && {1'b0, req.row} < out_count
                         && req.row == olast) begin
                        state_in = dlfb_pkg::ST_BWD_RD;
                        r_in = '0;
                        c_in = '0;
                     end
                  end
                  dlfb_pkg::CMD_RD_WG, dlfb_pkg::CMD_RD_BG: state_in = dlfb_pkg::ST_GR_RD;
                  default: ;
               endcase
            end
         end
         dlfb_pkg::ST_FWD_RD: begin
            state_in = dlfb_pkg::ST_FWD_MAC;
         end
         dlfb_pkg::ST_FWD_MAC: begin
            ctl.mac = 1'b1;
            // first product of a row starts from the row's bias
            if (c_ff == '0) begin
               ctl.clr_acc = 1'b1;
               ctl.use_bias = 1'b1;
            end
            if (c_ff == ilast) begin
               state_in = dlfb_pkg::ST_FWD_OUT;
            end else begin
               c_in = c_ff + 4'd1;
               state_in = dlfb_pkg::ST_FWD_RD;
            end
         end
         dlfb_pkg::ST_FWD_OUT: begin
            ctl.emit = 1'b1;
            ctl.kind = dlfb_pkg::KIND_FWD;
            ctl.last = (r_ff == olast);
            c_in = '0;
            if (r_ff == olast) begin
               state_in = dlfb_pkg::ST_IDLE;
            end else begin
               r_in = r_ff + 4'd1;
               state_in = dlfb_pkg::ST_FWD_RD;
            end
         end
         dlfb_pkg::ST_BWD_RD: state_in = dlfb_pkg::ST_BWD_UPD;
         dlfb_pkg::ST_BWD_UPD: begin
            ctl.wg_write = 1'b1;
            if (c_ff == '0) ctl.bg_write = 1'b1;
            if (c_ff == ilast) begin
               c_in = '0;
               if (r_ff == olast) begin
                  r_in = '0;
                  state_in = dlfb_pkg::ST_IG_RD;
               end else begin
                  r_in = r_ff + 4'd1;
                  state_in = dlfb_pkg::ST_BWD_RD;
               end
            end else begin
               c_in = c_ff + 4'd1;
               state_in = dlfb_pkg::ST_BWD_RD;
            end
         end
         dlfb_pkg::ST_IG_RD: begin
            if (r_ff == '0) ctl.clr_acc = 1'b1;
            state_in = dlfb_pkg::ST_IG_MAC;
         end
         dlfb_pkg::ST_IG_MAC: begin
            ctl.mac = 1'b1;
            if (r_ff == olast) begin
               state_in = dlfb_pkg::ST_IG_OUT;
            end else begin
               r_in = r_ff + 4'd1;
               state_in = dlfb_pkg::ST_IG_RD;
            end
         end
         dlfb_pkg::ST_IG_OUT: begin
            ctl.emit = 1'b1;
            ctl.kind = dlfb_pkg::KIND_IG;
            ctl.last = (c_ff == ilast);
            r_in = '0;
            if (c_ff == ilast) begin
               state_in = dlfb_pkg::ST_IDLE;
            end else begin
               c_in = c_ff + 4'd1;
               state_in = dlfb_pkg::ST_IG_RD;
            end
         end
         dlfb_pkg::ST_GR_RD: state_in = dlfb_pkg::ST_GR_OUT;
         dlfb_pkg::ST_GR_OUT: begin
            ctl.emit = 1'b1;
            ctl.kind = (cmd_ff == dlfb_pkg::CMD_RD_WG) ? dlfb_pkg::KIND_WG : dlfb_pkg::KIND_BG;
            ctl.last = 1'b1;
            state_in = dlfb_pkg::ST_IDLE;
         end
         default: state_in = dlfb_pkg::ST_IDLE;
      endcase
   end

   assign row_idx  = r_ff;
   assign col_idx  = c_ff;
   assign smp_idx  = s_ff;
   assign smp_zero = (s_ff == '0);
   assign cmd      = cmd_ff;
endmodule

// ----- design/dlfb_dp.sv -----
// Datapath: stores, multiply-accumulate unit and result register.
module dlfb_dp #(
   parameter int MAX_IN    = dlfb_pkg::MaxIn,
   parameter int MAX_OUT   = dlfb_pkg::MaxOut,
   parameter int MAX_BATCH = dlfb_pkg::MaxBatch
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  dlfb_pkg::req_type req,
   input  logic [4:0]        in_count,
   input  logic [4:0]        out_count,
   input  logic [3:0]        batch_count,
   input  logic [3:0]        row_idx,
   input  logic [3:0]        col_idx,
   input  logic [2:0]        smp_idx,
   input  logic              smp_zero,
   input  dlfb_pkg::cmd_type cmd,
   input  dlfb_pkg::ctl_type ctl,
   output logic              rsp_valid,
   output dlfb_pkg::rsp_type rsp
);
   localparam int WDepth = MAX_OUT * MAX_IN;
   localparam int ADepth = MAX_BATCH * MAX_IN;
   localparam int WA = $clog2(WDepth);
   localparam int AA = $clog2(ADepth);
   localparam int OA = $clog2(MAX_OUT);
   localparam int IA = $clog2(MAX_IN);
   localparam int BA = $clog2(MAX_BATCH);

   logic [15:0] w_rd, b_rd, a_rd, d_rd;
   logic [31:0] wg_rd, bg_rd;
   logic        w_we, b_we, a_we, d_we, wg_we, bg_we;
   logic [WA-1:0] w_waddr, w_raddr, wg_waddr, wg_raddr;
   logic [OA-1:0] b_waddr, b_raddr, d_waddr, d_raddr, bg_waddr, bg_raddr;
   logic [AA-1:0] a_waddr, a_raddr;
   logic [31:0] wg_wdata, bg_wdata;
   logic        in_row, in_col, in_req_range;
   logic [OA-1:0] r_o;
   logic [IA-1:0] c_i;

   assign r_o = OA'(row_idx);
   assign c_i = IA'(col_idx);
   assign in_row = (32'(req.row) < MAX_OUT);
   assign in_col = (32'(req.col) < MAX_IN);
   assign in_req_range = in_row && in_col;

   // store writes from accepted beats
   assign w_we = accept && req.command == dlfb_pkg::CMD_LOAD_W && in_req_range;
   assign b_we = accept && req.command == dlfb_pkg::CMD_LOAD_B && in_row;
   assign a_we = accept && req.command == dlfb_pkg::CMD_FWD
                 && {1'b0, req.sample} < batch_count && {1'b0, req.col} < in_count;
   assign d_we = accept && req.command == dlfb_pkg::CMD_BWD
                 && {1'b0, req.sample} < batch_count && {1'b0, req.row} < out_count;
   assign w_waddr = WA'(32'(req.row) * MAX_IN + 32'(req.col));
   assign b_waddr = OA'(req.row);
   assign d_waddr = OA'(req.row);
   assign a_waddr = AA'(32'(req.sample) * MAX_IN + 32'(req.col));

   // read addresses follow the sequencer indices
   assign w_raddr  = WA'(32'(r_o) * MAX_IN + 32'(c_i));
   assign b_raddr  = r_o;
   assign d_raddr  = r_o;
   assign a_raddr  = AA'(32'(smp_idx[BA > 0 ? BA-1 : 0:0]) * MAX_IN + 32'(c_i));
   assign wg_raddr = w_raddr;
   assign bg_raddr = r_o;

   dlfb_ram #(.Width(16), .Depth(WDepth)) u_w (.clock, .wr_en(w_we), .wr_addr(w_waddr),
      .wr_data(req.operand), .rd_addr(w_raddr), .rd_data(w_rd));
   dlfb_ram #(.Width(16), .Depth(MAX_OUT)) u_b (.clock, .wr_en(b_we), .wr_addr(b_waddr),
      .wr_data(req.operand), .rd_addr(b_raddr), .rd_data(b_rd));
   dlfb_ram #(.Width(16), .Depth(ADepth)) u_a (.clock, .wr_en(a_we), .wr_addr(a_waddr),
      .wr_data(req.operand), .rd_addr(a_raddr), .rd_data(a_rd));
   dlfb_ram #(.Width(16), .Depth(MAX_OUT)) u_d (.clock, .wr_en(d_we), .wr_addr(d_waddr),
      .wr_data(req.operand), .rd_addr(d_raddr), .rd_data(d_rd));
   dlfb_ram #(.Width(32), .Depth(WDepth)) u_wg (.clock, .wr_en(wg_we), .wr_addr(wg_waddr),
      .wr_data(wg_wdata), .rd_addr(wg_raddr), .rd_data(wg_rd));
   dlfb_ram #(.Width(32), .Depth(MAX_OUT)) u_bg (.clock, .wr_en(bg_we), .wr_addr(bg_waddr),
      .wr_data(bg_wdata), .rd_addr(bg_raddr), .rd_data(bg_rd));

   // multiplier: weight or activation times activation or dout
   logic signed [15:0] ma, mb;
   logic signed [31:0] prod;
   always_comb begin
      ma = $signed(w_rd);
      mb = $signed(a_rd);
      case (cmd)
         dlfb_pkg::CMD_FWD: begin
            ma = $signed(w_rd);
            mb = $signed(a_rd);
         end
         dlfb_pkg::CMD_BWD: begin
            ma = $signed(wg_we ? a_rd : w_rd);
            mb = $signed(d_rd);
         end
         default: ;
      endcase
   end
   assign prod = ma * mb;

   // gradient update
   logic signed [31:0] wg_base, bg_base;
   assign wg_base  = smp_zero ? 32'sd0 : $signed(wg_rd);
   assign bg_base  = smp_zero ? 32'sd0 : $signed(bg_rd);
   assign wg_we    = ctl.wg_write;
   assign bg_we    = ctl.bg_write;
   assign wg_waddr = w_raddr;
   assign bg_waddr = r_o;
   assign wg_wdata = dlfb_pkg::sat32(48'(wg_base) + 48'(prod));
   assign bg_wdata = dlfb_pkg::sat32(48'(bg_base) + 48'($signed({d_rd, 8'h00})));

   // accumulator: at most 16 products of 2^30 plus bias fits 48 bits
   logic signed [47:0] acc_ff, acc_in, acc_start;
   assign acc_start = ctl.use_bias ? 48'($signed({b_rd, 8'h00})) : 48'sd0;
   always_comb begin
      acc_in = acc_ff;
      if (ctl.mac) acc_in = (ctl.clr_acc ? acc_start : acc_ff) + 48'(prod);
      else if (ctl.clr_acc) acc_in = acc_start;
   end

   // gradient read value (out-of-range reads give zero)
   logic rd_oor_ff;
   logic signed [31:0] gval;
   assign gval = rd_oor_ff ? 32'sd0 : (cmd == dlfb_pkg::CMD_RD_WG ? wg_rd : bg_rd);

   dlfb_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.emit;
      end
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
      if (accept) rd_oor_ff <= (req.command == dlfb_pkg::CMD_RD_WG) ? !in_req_range : !in_row;
   end

   // result register
   always_comb begin
      rsp_in.kind  = ctl.kind;
      rsp_in.last  = ctl.last;
      rsp_in.index = row_idx;
      rsp_in.result = dlfb_pkg::sat32(acc_ff);
      case (dlfb_pkg::kind_type'(ctl.kind))
         dlfb_pkg::KIND_FWD: rsp_in.index = row_idx;
         dlfb_pkg::KIND_IG:  rsp_in.index = col_idx;
         dlfb_pkg::KIND_WG: begin
            rsp_in.index = col_idx;
            rsp_in.result = gval;
         end
         dlfb_pkg::KIND_BG: begin
            rsp_in.index = row_idx;
            rsp_in.result = gval;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
endmodule
